@@ src/msr_pkg.sv @@
// ============================================================================
// msr_pkg: shared types and codes for the masked pattern search and replace
// Holds the request codes, the command passed from front to back, the
// pattern entry layout and the result record.
// ============================================================================
package msr_pkg;

    localparam logic [1:0] OPC_LOAD = 2'd0;
    localparam logic [1:0] OPC_BYTE = 2'd1;
    localparam logic [1:0] OPC_END  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int OFFSET_W    = 24;
    localparam int REGF_W      = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_END  = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_SUMMARY = 2'd2
    } res_kind_t;

    typedef enum logic {
        BK_RUN   = 1'b0,
        BK_FLUSH = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [4:0] entry_index;
        logic [7:0] expected_byte;
        logic       expected_care;
        logic [7:0] replace_byte;
        logic       replace_enable;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic       repen;
        logic [7:0] rep;
        logic       care;
        logic [7:0] expb;
    } pat_entry_t;

    typedef struct packed {
        res_kind_t             kind;
        logic [7:0]            out_byte;
        logic [OFFSET_W-1:0]   start_offset;
        logic [REGF_W-1:0]     register_field;
        logic [OFFSET_W-1:0]   match_count;
        logic                  last;
    } res_t;

    function automatic res_t make_byte(input logic [7:0] b, input logic lst);
        res_t r;
        r                = '0;
        r.kind           = KIND_BYTE;
        r.out_byte       = b;
        r.last           = lst;
        return r;
    endfunction

endpackage

@@ src/msr_front.sv @@
// ============================================================================
// msr_front: request intake and classification
// Unpacks each request, drops unused codes and out-of-range loads, and
// stages the resulting command toward the queue.
// ============================================================================
module msr_front #(
    parameter int WINDOW_LEN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_op,
    input  logic [msr_pkg::IN_DATA_W-1:0] in_data,
    output logic                          push_valid,
    input  logic                          push_ready,
    output msr_pkg::cmd_t                 push_data
);
    import msr_pkg::*;

    logic stg_valid_reg;
    logic stg_valid_next;
    cmd_t stg_cmd_reg;
    cmd_t stg_cmd_next;
    cmd_t dec_cmd;
    logic dec_keep;
    logic push;
    logic take;

    always_comb
    begin
        dec_cmd                = '0;
        dec_cmd.entry_index    = in_data[4:0];
        dec_cmd.expected_byte  = in_data[12:5];
        dec_cmd.expected_care  = in_data[13];
        dec_cmd.replace_byte   = in_data[21:14];
        dec_cmd.replace_enable = in_data[22];
        dec_cmd.data_byte      = in_data[30:23];
        dec_keep               = 1'b0;
        unique case (in_op)
            OPC_LOAD:
            begin
                dec_cmd.op = CMD_LOAD;
                dec_keep   = (int'(in_data[4:0]) < WINDOW_LEN);
            end
            OPC_BYTE:
            begin
                dec_cmd.op = CMD_BYTE;
                dec_keep   = 1'b1;
            end
            OPC_END:
            begin
                dec_cmd.op = CMD_END;
                dec_keep   = 1'b1;
            end
            default:
            begin
                dec_cmd.op = CMD_LOAD;
                dec_keep   = 1'b0;
            end
        endcase
    end

    assign push       = stg_valid_reg && push_ready;
    assign in_ready   = !stg_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = stg_valid_reg;
    assign push_data  = stg_cmd_reg;

    always_comb
    begin
        stg_cmd_next = stg_cmd_reg;
        if (take)
        begin
            stg_valid_next = dec_keep;
            stg_cmd_next   = dec_cmd;
        end
        else if (push)
        begin
            stg_valid_next = 1'b0;
        end
        else
        begin
            stg_valid_next = stg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_cmd_reg <= stg_cmd_next;
    end

endmodule

@@ src/msr_queue.sv @@
// ============================================================================
// msr_queue: command queue between front and back
// Small first-in first-out buffer so that intake and execution stall apart.
// ============================================================================
module msr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  msr_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output msr_pkg::cmd_t pop_data
);
    import msr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/msr_back.sv @@
// ============================================================================
// msr_back: window execution and result output
// Holds the pattern table and byte window, compares and patches full
// windows, flushes at end of buffer and drives the registered result.
// ============================================================================
module msr_back #(
    parameter int WINDOW_LEN    = 32,
    parameter int POSITION_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  msr_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output msr_pkg::res_t res
);
    import msr_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam logic [FILL_W-1:0]        FULL_FILL = FILL_W'(WINDOW_LEN - 1);
    localparam logic [POSITION_BITS-1:0] LAG       = POSITION_BITS'(WINDOW_LEN - 1);

    back_state_t              phase_reg;
    back_state_t              phase_next;
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic [FILL_W-1:0]        skip_reg;
    logic [FILL_W-1:0]        skip_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] cnt_reg;
    logic [POSITION_BITS-1:0] cnt_next;
    logic [POSITION_BITS-1:0] cnt_sat;
    logic [POSITION_BITS-1:0] start;
    logic [OFFSET_W-1:0]      last_off_reg;
    logic [OFFSET_W-1:0]      last_off_next;
    logic [REGF_W-1:0]        last_rf_reg;
    logic [REGF_W-1:0]        last_rf_next;
    logic                     patch_en_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    res_t                     out_reg;
    res_t                     out_next;
    logic                     pend_valid_reg;
    logic                     pend_valid_next;
    res_t                     pend_reg;
    res_t                     pend_next;
    pat_entry_t               tbl_reg  [WINDOW_LEN];
    pat_entry_t               tbl_next [WINDOW_LEN];
    logic [7:0]               win_reg  [WINDOW_LEN];
    logic [7:0]               win_next [WINDOW_LEN];
    logic [7:0]               full_win [WINDOW_LEN];
    logic [7:0]               patched  [WINDOW_LEN];
    logic                     hit;
    logic                     is_full;
    logic                     out_free;
    logic                     cmd_emits;
    logic                     pop;
    res_t                     rpt;

    assign is_full   = (fill_reg == FULL_FILL);
    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_emits = (cmd.op == CMD_BYTE) && is_full;
    assign pop       = (phase_reg == BK_RUN) && !pend_valid_reg && cmd_valid
                       && (out_free || !cmd_emits);
    assign cmd_ready = pop;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cnt_sat   = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;
    assign start     = (pos_reg >= LAG) ? pos_reg - LAG : '0;

    always_comb
    begin
        hit = 1'b1;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            full_win[i] = (FILL_W'(i) == fill_reg) ? cmd.data_byte : win_reg[i];
            if (tbl_reg[i].care && (full_win[i] != tbl_reg[i].expb))
            begin
                hit = 1'b0;
            end
            patched[i] = (patch_en_reg && tbl_reg[i].repen) ? tbl_reg[i].rep : full_win[i];
        end
    end

    always_comb
    begin
        rpt                = '0;
        rpt.kind           = KIND_REPORT;
        rpt.start_offset   = OFFSET_W'(start);
        rpt.register_field = full_win[0][REGF_W-1:0];
        rpt.match_count    = OFFSET_W'(cnt_sat);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        fill_next       = fill_reg;
        skip_next       = skip_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        last_off_next   = last_off_reg;
        last_rf_next    = last_rf_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        tbl_next        = tbl_reg;
        win_next        = win_reg;

        if (pend_valid_reg && out_free)
        begin
            out_next        = pend_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                BK_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (fill_reg != '0)
                        begin
                            out_next  = make_byte(win_reg[0], 1'b0);
                            fill_next = fill_reg - 1'b1;
                            for (int i = 0; i < WINDOW_LEN - 1; i++)
                            begin
                                win_next[i] = win_reg[i + 1];
                            end
                        end
                        else
                        begin
                            out_next                = '0;
                            out_next.kind           = KIND_SUMMARY;
                            out_next.start_offset   = last_off_reg;
                            out_next.register_field = last_rf_reg;
                            out_next.match_count    = OFFSET_W'(cnt_reg);
                            out_next.last           = 1'b1;
                            skip_next               = '0;
                            pos_next                = '0;
                            cnt_next                = '0;
                            last_off_next           = '0;
                            last_rf_next            = '0;
                            phase_next              = BK_RUN;
                        end
                    end
                end
                BK_RUN:
                begin
                    if (pop)
                    begin
                        unique case (cmd.op)
                            CMD_LOAD:
                            begin
                                for (int i = 0; i < WINDOW_LEN; i++)
                                begin
                                    if (int'(cmd.entry_index) == i)
                                    begin
                                        tbl_next[i].expb  = cmd.expected_byte;
                                        tbl_next[i].care  = cmd.expected_care;
                                        tbl_next[i].rep   = cmd.replace_byte;
                                        tbl_next[i].repen = cmd.replace_enable;
                                    end
                                end
                            end
                            CMD_BYTE:
                            begin
                                if (pos_reg != '1)
                                begin
                                    pos_next = pos_reg + 1'b1;
                                end
                                if (!is_full)
                                begin
                                    win_next  = full_win;
                                    fill_next = fill_reg + 1'b1;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    if (skip_reg != '0)
                                    begin
                                        skip_next = skip_reg - 1'b1;
                                        out_next  = make_byte(full_win[0], 1'b1);
                                        for (int i = 0; i < WINDOW_LEN - 1; i++)
                                        begin
                                            win_next[i] = full_win[i + 1];
                                        end
                                    end
                                    else if (hit)
                                    begin
                                        cnt_next        = cnt_sat;
                                        last_off_next   = rpt.start_offset;
                                        last_rf_next    = rpt.register_field;
                                        skip_next       = FULL_FILL;
                                        out_next        = rpt;
                                        pend_next       = make_byte(patched[0], 1'b1);
                                        pend_valid_next = 1'b1;
                                        for (int i = 0; i < WINDOW_LEN - 1; i++)
                                        begin
                                            win_next[i] = patched[i + 1];
                                        end
                                    end
                                    else
                                    begin
                                        out_next = make_byte(full_win[0], 1'b1);
                                        for (int i = 0; i < WINDOW_LEN - 1; i++)
                                        begin
                                            win_next[i] = full_win[i + 1];
                                        end
                                    end
                                end
                            end
                            CMD_END:
                            begin
                                phase_next = BK_FLUSH;
                            end
                            default:
                            begin
                                phase_next = BK_RUN;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = BK_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= BK_RUN;
            fill_reg       <= '0;
            skip_reg       <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            last_off_reg   <= '0;
            last_rf_reg    <= '0;
            patch_en_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            fill_reg       <= fill_next;
            skip_reg       <= skip_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            last_off_reg   <= last_off_next;
            last_rf_reg    <= last_rf_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            tbl_reg        <= tbl_next;
            if (cfg_valid)
            begin
                patch_en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
        win_reg  <= win_next;
    end

endmodule

@@ src/masked_pattern_search_replace.sv @@
// A request passes the front stage register and the queue before the back end
// registers its result. Throughput: one data byte per cycle unless the output,
// a pending byte or a flush stalls, set by the combinational window compare; a
// match emits its report, then its patched byte. End of buffer flushes the window
// byte by byte, then the summary. Reset: clears counters, empties the window,
// sets all pattern entries to wildcard with no replacement, and sets patching on.
// ============================================================================
// masked_pattern_search_replace: wildcard byte pattern search and replace
// Streams bytes through a pattern-length window, reports non-overlapping
// matches, optionally patches them, and summarizes at end of buffer.
// ============================================================================
module masked_pattern_search_replace #(
    parameter int WINDOW_LEN    = 32,
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // patch_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[4:0], expected_byte[12:5], expected_care[13],
    // replace_byte[21:14], replace_enable[22], data_byte[30:23]
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,      // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0], start_offset[31:8], register_field[36:32], match_count[60:37]
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,      // kind
    output logic        m_tlast
);
    import msr_pkg::*;

    logic q_push_valid;
    logic q_push_ready;
    cmd_t q_push_data;
    logic q_pop_valid;
    logic q_pop_ready;
    cmd_t q_pop_data;
    res_t res;

    assign cfg_ready = 1'b1;

    msr_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_data    (s_tdata),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    msr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    msr_back #(
        .WINDOW_LEN    (WINDOW_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (q_pop_valid),
        .cmd_ready (q_pop_ready),
        .cmd       (q_pop_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {3'b000, res.match_count, res.register_field,
                      res.start_offset, res.out_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
